// ===== src/cal_pkg.sv =====
// ----------------------------------------------------------------------------
// cal_pkg
// Types, limits and calendar helpers shared by the calendar counter.
// ----------------------------------------------------------------------------
package cal_pkg;

    localparam logic [5:0]  SEC_LAST   = 6'd59;
    localparam logic [5:0]  MIN_LAST   = 6'd59;
    localparam logic [4:0]  HOUR_LAST  = 5'd23;
    localparam logic [3:0]  MONTH_LAST = 4'd12;
    localparam logic [13:0] YEAR_LAST  = 14'd9999;

    typedef enum logic [1:0] {
        MODE_UP   = 2'd0,
        MODE_DOWN = 2'd1,
        MODE_LOAD = 2'd2,
        MODE_NONE = 2'd3
    } t_mode;

    typedef struct packed {
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
    } t_time;

    localparam logic [4:0] MONTH_DAYS [16] = '{
        5'd31, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
        5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd31, 5'd31
    };

    // year / 100 through the reciprocal of 25 on year / 4
    function automatic logic is_leap(input logic [13:0] year);
        logic [11:0] quarter;
        logic [24:0] prod;
        logic [7:0]  cent;
        logic [11:0] back;
        logic        by4;
        logic        by100;
        quarter = year[13:2];
        prod    = 25'(quarter) * 25'd5243;
        cent    = prod[24:17];
        back    = 12'(12'(cent) * 12'd25);
        by4     = (year[1:0] == 2'd0);
        by100   = by4 && (back == quarter);
        return by4 && (!by100 || (cent[1:0] == 2'd0));
    endfunction

    function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
        if (month == 4'd2 && leap) begin
            return 5'd29;
        end
        return MONTH_DAYS[month];
    endfunction

endpackage

// ===== src/cal_next.sv =====
// ----------------------------------------------------------------------------
// cal_next
// Next date-time for one request: tick up, tick down, checked load or hold.
// ----------------------------------------------------------------------------
module cal_next
    import cal_pkg::*;
(
    input  t_time       i_cur,
    input  logic        i_leap,
    input  t_mode       i_mode,
    input  t_time       i_load,
    output t_time       o_nxt,
    output logic        o_nxt_leap,
    output logic        o_rejected
);

    t_time       up_t;
    t_time       dn_t;
    logic        sec_c, min_c, hr_c, day_c, mon_c;
    logic        sec_b, min_b, hr_b, day_b, mon_b;
    logic [13:0] year_inc;
    logic [13:0] year_dec;
    logic [3:0]  prev_month;
    logic        load_leap;
    logic        load_ok;

    // carry chain
    always_comb begin
        sec_c = (i_cur.second >= SEC_LAST);
        min_c = sec_c && (i_cur.minute >= MIN_LAST);
        hr_c  = min_c && (i_cur.hour >= HOUR_LAST);
        day_c = hr_c && (i_cur.day >= days_in(i_cur.month, i_leap));
        mon_c = day_c && (i_cur.month >= MONTH_LAST);
        year_inc = (i_cur.year >= YEAR_LAST) ? 14'd0 : 14'(i_cur.year + 14'd1);

        up_t.second = sec_c ? 6'd0 : 6'(i_cur.second + 6'd1);
        up_t.minute = !sec_c ? i_cur.minute : (min_c ? 6'd0 : 6'(i_cur.minute + 6'd1));
        up_t.hour   = !min_c ? i_cur.hour : (hr_c ? 5'd0 : 5'(i_cur.hour + 5'd1));
        up_t.day    = !hr_c ? i_cur.day : (day_c ? 5'd1 : 5'(i_cur.day + 5'd1));
        up_t.month  = !day_c ? i_cur.month : (mon_c ? 4'd1 : 4'(i_cur.month + 4'd1));
        up_t.year   = mon_c ? year_inc : i_cur.year;
    end

    // borrow chain
    always_comb begin
        sec_b = (i_cur.second == 6'd0);
        min_b = sec_b && (i_cur.minute == 6'd0);
        hr_b  = min_b && (i_cur.hour == 5'd0);
        day_b = hr_b && (i_cur.day <= 5'd1);
        mon_b = day_b && (i_cur.month <= 4'd1);
        year_dec   = (i_cur.year == 14'd0) ? YEAR_LAST : 14'(i_cur.year - 14'd1);
        prev_month = (i_cur.month <= 4'd1) ? MONTH_LAST : 4'(i_cur.month - 4'd1);

        dn_t.second = sec_b ? SEC_LAST : 6'(i_cur.second - 6'd1);
        dn_t.minute = !sec_b ? i_cur.minute : (min_b ? MIN_LAST : 6'(i_cur.minute - 6'd1));
        dn_t.hour   = !min_b ? i_cur.hour : (hr_b ? HOUR_LAST : 5'(i_cur.hour - 5'd1));
        // a borrow into december never needs the leap flag
        dn_t.day    = !hr_b ? i_cur.day :
                      (day_b ? days_in(prev_month, i_leap) : 5'(i_cur.day - 5'd1));
        dn_t.month  = day_b ? prev_month : i_cur.month;
        dn_t.year   = mon_b ? year_dec : i_cur.year;
    end

    // load check
    always_comb begin
        load_leap = is_leap(i_load.year);
        load_ok   = (i_load.second <= SEC_LAST) && (i_load.minute <= MIN_LAST) &&
                    (i_load.hour <= HOUR_LAST) && (i_load.month >= 4'd1) &&
                    (i_load.month <= MONTH_LAST) && (i_load.year <= YEAR_LAST) &&
                    (i_load.day >= 5'd1) &&
                    (i_load.day <= days_in(i_load.month, load_leap));
    end

    always_comb begin
        o_nxt      = i_cur;
        o_nxt_leap = i_leap;
        o_rejected = 1'b0;
        case (i_mode)
            MODE_UP: begin
                o_nxt = up_t;
                if (mon_c) begin
                    o_nxt_leap = is_leap(year_inc);
                end
            end
            MODE_DOWN: begin
                o_nxt = dn_t;
                if (mon_b) begin
                    o_nxt_leap = is_leap(year_dec);
                end
            end
            MODE_LOAD: begin
                if (load_ok) begin
                    o_nxt      = i_load;
                    o_nxt_leap = load_leap;
                end else begin
                    o_rejected = 1'b1;
                end
            end
            default: begin
                o_nxt = i_cur;
            end
        endcase
    end

endmodule

// ===== src/calendar_time_up_down_counter.sv =====
// ----------------------------------------------------------------------------
// calendar_time_up_down_counter
// Gregorian date and time of day counter with tick up, tick down and load.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid / o_stall carries one request: i_mode selects add
//   one second, subtract one second or load i_load_* as a new date-time.
//   A load with any field out of range leaves the date-time unchanged and
//   returns o_load_rejected high.
//   Output channel o_valid / i_stall returns exactly one result per request:
//   the date-time after the request and the reject flag.
//   A request passes the input register and then the result register, which
//   is the date-time register itself, on its way to o_valid.
//   Throughput is one request per cycle while no result is held by i_stall,
//   set by the combinational carry and borrow chain with its leap-year check.
//   While i_stall holds a result, one more request is taken into the input
//   register; o_stall rises only once that register is also full.
//   Synchronous reset sets 0000-01-01 00:00:00 and empties both registers.
// ----------------------------------------------------------------------------
module calendar_time_up_down_counter
    import cal_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_mode,
    input  logic [5:0]  i_load_second,
    input  logic [5:0]  i_load_minute,
    input  logic [4:0]  i_load_hour,
    input  logic [4:0]  i_load_day,
    input  logic [3:0]  i_load_month,
    input  logic [13:0] i_load_year,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [5:0]  o_second_now,
    output logic [5:0]  o_minute_now,
    output logic [4:0]  o_hour_now,
    output logic [4:0]  o_day_now,
    output logic [3:0]  o_month_now,
    output logic [13:0] o_year_now,
    output logic        o_load_rejected
);

    logic  r_in_valid;
    t_mode r_mode;
    t_time r_load;
    t_time r_time;
    logic  r_leap;
    logic  r_out_valid;
    logic  r_rejected;

    t_time n_time;
    logic  n_leap;
    logic  n_rejected;
    logic  out_free;
    logic  advance;
    logic  take;

    assign out_free = !r_out_valid || !i_stall;
    assign advance  = r_in_valid && out_free;
    assign take     = i_valid && (!r_in_valid || out_free);
    assign o_stall  = r_in_valid && !out_free;

    cal_next u_cal_next (
        .i_cur      (r_time),
        .i_leap     (r_leap),
        .i_mode     (r_mode),
        .i_load     (r_load),
        .o_nxt      (n_time),
        .o_nxt_leap (n_leap),
        .o_rejected (n_rejected)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_mode        <= t_mode'(i_mode);
            r_load.second <= i_load_second;
            r_load.minute <= i_load_minute;
            r_load.hour   <= i_load_hour;
            r_load.day    <= i_load_day;
            r_load.month  <= i_load_month;
            r_load.year   <= i_load_year;
        end
    end

    // date-time and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time.second <= 6'd0;
            r_time.minute <= 6'd0;
            r_time.hour   <= 5'd0;
            r_time.day    <= 5'd1;
            r_time.month  <= 4'd1;
            r_time.year   <= 14'd0;
            r_leap        <= 1'b1;
            r_out_valid   <= 1'b0;
            r_rejected    <= 1'b0;
        end else begin
            if (advance) begin
                r_time     <= n_time;
                r_leap     <= n_leap;
                r_rejected <= n_rejected;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_second_now    = r_time.second;
    assign o_minute_now    = r_time.minute;
    assign o_hour_now      = r_time.hour;
    assign o_day_now       = r_time.day;
    assign o_month_now     = r_time.month;
    assign o_year_now      = r_time.year;
    assign o_load_rejected = r_rejected;

endmodule

// ===== src/cal_checker.sv =====
// ----------------------------------------------------------------------------
// cal_checker
// Port-level checks on the calendar counter, bound to the top level.
// ----------------------------------------------------------------------------
module cal_checker
    import cal_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [5:0]  o_second_now,
    input logic [5:0]  o_minute_now,
    input logic [4:0]  o_hour_now,
    input logic [4:0]  o_day_now,
    input logic [3:0]  o_month_now,
    input logic [13:0] o_year_now,
    input logic        o_load_rejected
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_second_now) &&
        $stable(o_minute_now) && $stable(o_hour_now) && $stable(o_day_now) &&
        $stable(o_month_now) && $stable(o_year_now) && $stable(o_load_rejected))
        else $error("result changed while stalled");

    // delivered date-time always in range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_second_now <= SEC_LAST) && (o_minute_now <= MIN_LAST) &&
        (o_hour_now <= HOUR_LAST) && (o_day_now >= 5'd1) && (o_day_now <= 5'd31) &&
        (o_month_now >= 4'd1) && (o_month_now <= MONTH_LAST) &&
        (o_year_now <= YEAR_LAST))
        else $error("date-time out of range");

    // one request buffered behind a stalled result fills the block
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && o_valid && i_stall) ##1 i_stall |-> o_stall)
        else $error("request taken past a full block");

    // reset empties the output
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind calendar_time_up_down_counter cal_checker u_cal_checker (.*);

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the calendar time up/down counter: directed date
// boundaries, then boundary-seeded tick runs with random loads, under random
// request gaps, result back-pressure and a long output hold.
// ----------------------------------------------------------------------------
module tb_top;
    import cal_pkg::*;

    typedef struct packed {
        t_time stamp;
        logic  rejected;
    } t_clock_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_mode;
    logic [5:0]  i_load_second;
    logic [5:0]  i_load_minute;
    logic [4:0]  i_load_hour;
    logic [4:0]  i_load_day;
    logic [3:0]  i_load_month;
    logic [13:0] i_load_year;
    logic        o_valid;
    logic        i_stall;
    logic [5:0]  o_second_now;
    logic [5:0]  o_minute_now;
    logic [4:0]  o_hour_now;
    logic [4:0]  o_day_now;
    logic [3:0]  o_month_now;
    logic [13:0] o_year_now;
    logic        o_load_rejected;

    t_time         clock_model;
    t_clock_result expected_readings[$];
    int            mismatch_count = 0;
    int            send_gap_max   = 0;
    int            stall_max      = 0;
    int            hold_request   = 0;

    calendar_time_up_down_counter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_mode          (i_mode),
        .i_load_second   (i_load_second),
        .i_load_minute   (i_load_minute),
        .i_load_hour     (i_load_hour),
        .i_load_day      (i_load_day),
        .i_load_month    (i_load_month),
        .i_load_year     (i_load_year),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_second_now    (o_second_now),
        .o_minute_now    (o_minute_now),
        .o_hour_now      (o_hour_now),
        .o_day_now       (o_day_now),
        .o_month_now     (o_month_now),
        .o_year_now      (o_year_now),
        .o_load_rejected (o_load_rejected)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // calendar arithmetic
    function automatic bit gregorian_leap(input int year);
        return ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
    endfunction

    function automatic logic [4:0] month_length(input logic [3:0] month,
                                                input logic [13:0] year);
        if (month == 4'd2) begin
            return gregorian_leap(int'(year)) ? 5'd29 : 5'd28;
        end
        if (month == 4'd4 || month == 4'd6 || month == 4'd9 || month == 4'd11) begin
            return 5'd30;
        end
        return 5'd31;
    endfunction

    function automatic t_time make_time(input int year, input int month, input int day,
                                        input int hour, input int minute, input int second);
        t_time t;
        t.year   = 14'(year);
        t.month  = 4'(month);
        t.day    = 5'(day);
        t.hour   = 5'(hour);
        t.minute = 6'(minute);
        t.second = 6'(second);
        return t;
    endfunction

    function automatic t_time second_later(input t_time t);
        t_time n;
        n = t;
        if (n.second < SEC_LAST) begin
            n.second = n.second + 6'd1;
            return n;
        end
        n.second = '0;
        if (n.minute < MIN_LAST) begin
            n.minute = n.minute + 6'd1;
            return n;
        end
        n.minute = '0;
        if (n.hour < HOUR_LAST) begin
            n.hour = n.hour + 5'd1;
            return n;
        end
        n.hour = '0;
        if (n.day < month_length(n.month, n.year)) begin
            n.day = n.day + 5'd1;
            return n;
        end
        n.day = 5'd1;
        if (n.month < MONTH_LAST) begin
            n.month = n.month + 4'd1;
            return n;
        end
        n.month = 4'd1;
        n.year  = (n.year >= YEAR_LAST) ? 14'd0 : n.year + 14'd1;
        return n;
    endfunction

    function automatic t_time second_earlier(input t_time t);
        t_time n;
        n = t;
        if (n.second != 0) begin
            n.second = n.second - 6'd1;
            return n;
        end
        n.second = SEC_LAST;
        if (n.minute != 0) begin
            n.minute = n.minute - 6'd1;
            return n;
        end
        n.minute = MIN_LAST;
        if (n.hour != 0) begin
            n.hour = n.hour - 5'd1;
            return n;
        end
        n.hour = HOUR_LAST;
        if (n.day > 1) begin
            n.day = n.day - 5'd1;
            return n;
        end
        if (n.month > 1) begin
            n.month = n.month - 4'd1;
        end else begin
            n.month = MONTH_LAST;
            n.year  = (n.year == 0) ? YEAR_LAST : n.year - 14'd1;
        end
        n.day = month_length(n.month, n.year);
        return n;
    endfunction

    function automatic bit load_in_range(input t_time ld);
        if (ld.second > SEC_LAST || ld.minute > MIN_LAST || ld.hour > HOUR_LAST) begin
            return 1'b0;
        end
        if (ld.month < 1 || ld.month > MONTH_LAST || ld.year > YEAR_LAST) begin
            return 1'b0;
        end
        return ld.day >= 1 && ld.day <= month_length(ld.month, ld.year);
    endfunction

    // updates the model and returns the reject flag
    function automatic logic apply_request(input t_mode mode, input t_time ld);
        logic rejected;
        rejected = 1'b0;
        case (mode)
            MODE_UP: begin
                clock_model = second_later(clock_model);
            end
            MODE_DOWN: begin
                clock_model = second_earlier(clock_model);
            end
            MODE_LOAD: begin
                if (load_in_range(ld)) begin
                    clock_model = ld;
                end else begin
                    rejected = 1'b1;
                end
            end
            default: begin
            end
        endcase
        return rejected;
    endfunction

    // stimulus generation
    function automatic t_time random_fields();
        t_time t;
        t.second = 6'($urandom);
        t.minute = 6'($urandom);
        t.hour   = 5'($urandom);
        t.day    = 5'($urandom);
        t.month  = 4'($urandom);
        t.year   = 14'($urandom);
        return t;
    endfunction

    // valid date-time near the end of a year, month or day, or near its start
    function automatic t_time boundary_date(input bit near_top);
        t_time t;
        case ($urandom_range(0, 5))
            0:       t.year = 14'd0;
            1:       t.year = YEAR_LAST;
            2:       t.year = 14'($urandom_range(0, 24) * 400);
            3:       t.year = 14'($urandom_range(0, 99) * 100);
            4:       t.year = 14'($urandom_range(0, 2499) * 4);
            default: t.year = 14'($urandom_range(0, 9999));
        endcase
        t.month = 4'($urandom_range(1, 12));
        if ($urandom_range(0, 3) == 0) begin
            t.month = near_top ? MONTH_LAST : 4'd1;
        end
        if (near_top) begin
            t.day    = month_length(t.month, t.year);
            t.hour   = HOUR_LAST;
            t.minute = MIN_LAST;
            t.second = 6'(59 - $urandom_range(0, 3));
        end else begin
            t.day    = 5'd1;
            t.hour   = '0;
            t.minute = '0;
            t.second = 6'($urandom_range(0, 3));
        end
        case ($urandom_range(0, 7))
            0: t.day    = 5'($urandom_range(1, int'(month_length(t.month, t.year))));
            1: t.hour   = 5'($urandom_range(0, 23));
            2: t.minute = 6'($urandom_range(0, 59));
            default: begin
            end
        endcase
        return t;
    endfunction

    // valid date-time with exactly one field pushed out of range
    function automatic t_time broken_date();
        t_time t;
        int    days;
        t    = boundary_date(1'($urandom_range(0, 1)));
        days = int'(month_length(t.month, t.year));
        case ($urandom_range(0, 6))
            0: t.second = 6'($urandom_range(60, 63));
            1: t.minute = 6'($urandom_range(60, 63));
            2: t.hour   = 5'($urandom_range(24, 31));
            3: t.day    = 5'd0;
            4: t.day    = (days < 31) ? 5'($urandom_range(days + 1, 31)) : 5'd0;
            5: t.month  = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(13, 15));
            default: t.year = 14'($urandom_range(10000, 16383));
        endcase
        return t;
    endfunction

    // request channel
    task automatic send_request(input t_mode mode, input t_time ld);
        int            gap;
        t_clock_result reading;
        gap = (send_gap_max == 0) ? 0 : $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_mode        <= mode;
        i_load_second <= ld.second;
        i_load_minute <= ld.minute;
        i_load_hour   <= ld.hour;
        i_load_day    <= ld.day;
        i_load_month  <= ld.month;
        i_load_year   <= ld.year;
        do @(posedge i_clk); while (o_stall);
        reading.rejected = apply_request(mode, ld);
        reading.stamp    = clock_model;
        expected_readings.push_back(reading);
        @(negedge i_clk);
    endtask

    task automatic wait_drain();
        i_valid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic random_burst(input int count);
        int    sent;
        int    run;
        int    k;
        bit    going_up;
        t_mode m;
        sent = 0;
        while (sent < count) begin
            case ($urandom_range(0, 9))
                0: begin
                    send_request(t_mode'($urandom_range(0, 3)), random_fields());
                    sent++;
                end
                1: begin
                    send_request(MODE_LOAD, broken_date());
                    sent++;
                end
                default: begin
                    going_up = 1'($urandom_range(0, 1));
                    send_request(MODE_LOAD, boundary_date(going_up));
                    sent++;
                    run = $urandom_range(1, 8);
                    repeat (run) begin
                        k = $urandom_range(0, 11);
                        if (k == 0) begin
                            m = MODE_NONE;
                        end else if (k < 3) begin
                            m = going_up ? MODE_DOWN : MODE_UP;
                        end else begin
                            m = going_up ? MODE_UP : MODE_DOWN;
                        end
                        send_request(m, random_fields());
                        sent++;
                    end
                end
            endcase
        end
    endtask

    // tests
    task automatic test_directed_boundaries();
        send_gap_max = 3;
        stall_max    = 3;
        send_request(MODE_UP, random_fields());
        send_request(MODE_DOWN, random_fields());
        send_request(MODE_DOWN, random_fields());
        send_request(MODE_UP, random_fields());
        send_request(MODE_LOAD, make_time(9999, 12, 31, 23, 59, 59));
        send_request(MODE_UP, random_fields());
        send_request(MODE_NONE, make_time(16383, 15, 31, 31, 63, 63));
        send_request(MODE_LOAD, make_time(16383, 15, 31, 31, 63, 63));
        send_request(MODE_LOAD, make_time(0, 0, 0, 0, 0, 0));
        send_request(MODE_LOAD, make_time(2024, 6, 15, 12, 30, 60));
        send_request(MODE_LOAD, make_time(2024, 6, 15, 12, 60, 30));
        send_request(MODE_LOAD, make_time(2024, 6, 15, 24, 30, 30));
        send_request(MODE_LOAD, make_time(2024, 13, 15, 12, 30, 30));
        send_request(MODE_LOAD, make_time(10000, 6, 15, 12, 30, 30));
        send_request(MODE_LOAD, make_time(2024, 4, 31, 12, 30, 30));
        send_request(MODE_LOAD, make_time(1900, 2, 29, 0, 0, 0));
        send_request(MODE_LOAD, make_time(2023, 2, 29, 0, 0, 0));
        send_request(MODE_LOAD, make_time(2000, 2, 29, 23, 59, 59));
        send_request(MODE_UP, random_fields());
        send_request(MODE_DOWN, random_fields());
        send_request(MODE_LOAD, make_time(0, 2, 28, 23, 59, 59));
        send_request(MODE_UP, random_fields());
        send_request(MODE_LOAD, make_time(2100, 2, 28, 23, 59, 59));
        send_request(MODE_UP, random_fields());
        send_request(MODE_LOAD, make_time(2024, 3, 1, 0, 0, 0));
        send_request(MODE_DOWN, random_fields());
        wait_drain();
    endtask

    task automatic test_carry_runs();
        send_gap_max = 19;
        stall_max    = 19;
        random_burst(600);
        wait_drain();
    endtask

    task automatic test_back_to_back();
        send_gap_max = 0;
        stall_max    = 0;
        random_burst(250);
        wait_drain();
    endtask

    task automatic test_output_hold();
        send_gap_max = 0;
        stall_max    = 0;
        hold_request = 300;
        random_burst(40);
        wait_drain();
    endtask

    task automatic test_pause_for_results();
        send_gap_max = 19;
        stall_max    = 19;
        repeat (5) begin
            random_burst(100);
            wait_drain();
        end
    endtask

    // result channel back-pressure
    initial begin : result_sink
        int hold;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            hold = (stall_max == 0) ? 0 : $urandom_range(0, stall_max);
            if (hold_request != 0) begin
                hold         = hold_request;
                hold_request = 0;
            end
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    task automatic compare_field(input string field, input logic [13:0] want,
                                 input logic [13:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_clock_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_readings.size() == 0) begin
                $display("%0t: result with no request outstanding", $time);
                mismatch_count++;
            end else begin
                want = expected_readings.pop_front();
                compare_field("second", 14'(want.stamp.second), 14'(o_second_now));
                compare_field("minute", 14'(want.stamp.minute), 14'(o_minute_now));
                compare_field("hour", 14'(want.stamp.hour), 14'(o_hour_now));
                compare_field("day", 14'(want.stamp.day), 14'(o_day_now));
                compare_field("month", 14'(want.stamp.month), 14'(o_month_now));
                compare_field("year", want.stamp.year, o_year_now);
                compare_field("load_rejected", 14'(want.rejected), 14'(o_load_rejected));
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_mode        = MODE_NONE;
        i_load_second = '0;
        i_load_minute = '0;
        i_load_hour   = '0;
        i_load_day    = '0;
        i_load_month  = '0;
        i_load_year   = '0;
        clock_model   = make_time(0, 1, 1, 0, 0, 0);
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed_boundaries();
        test_carry_runs();
        test_back_to_back();
        test_output_hold();
        test_pause_for_results();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== calendar_time_up_down_counter.f =====
src/cal_pkg.sv
src/cal_next.sv
src/calendar_time_up_down_counter.sv
src/cal_checker.sv
sim/tb_top.sv
